// ----- src/ntc_filter_and_temperature_lookup_core_assert.svh -----
// ----------------------------------------------------------------------------
// NTC core assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NTC_FILTER_AND_TEMPERATURE_LOOKUP_CORE_ASSERT_SVH
`define NTC_FILTER_AND_TEMPERATURE_LOOKUP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clk edge out of reset.
`define NTCFTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntcftl assertion failed");
// Next-cycle implication.
`define NTCFTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntcftl assertion failed");
`else
`define NTCFTL_ASSERT_NOW(label, ante, cons)
`define NTCFTL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/ntcftl_pkg.sv -----
// ----------------------------------------------------------------------------
// NTC filter and lookup package
// Widths, register indexes, handshake structs and the calibration table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcftl_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CODE_W     = 8;
  localparam int TEMP_W     = 7;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CODE_SHIFT = SAMPLE_W - CODE_W;

  localparam int TEMP_TOP   = 72;
  localparam int ROM_LAST   = 72;
  localparam logic [TEMP_W-1:0] TOP_IDX =
    TEMP_W'((TEMP_TOP < ROM_LAST) ? TEMP_TOP : ROM_LAST);

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH     = 2'd2;

  localparam logic [SAMPLE_W-1:0] OPEN_LIMIT_RST  = 12'd512;
  localparam logic [SAMPLE_W-1:0] SHORT_LIMIT_RST = 12'd3200;
  localparam logic [COUNT_W-1:0]  PUBLISH_RST     = 8'd10;
  localparam logic [SAMPLE_W-1:0] LEVEL_RST       = 12'd2048;
  localparam logic [TEMP_W-1:0]   TEMP_RST        = 7'd25;

  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] code;
  } ntcftl_walk_req_t;

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] temp;
  } ntcftl_walk_rsp_t;

  // Calibration code per whole degree C, strictly increasing
  function automatic logic [CODE_W-1:0] cal_code(input logic [TEMP_W-1:0] idx);
    logic [CODE_W-1:0] c;
    unique case (idx)
      7'd0:  c = 8'd40;   7'd1:  c = 8'd41;   7'd2:  c = 8'd43;   7'd3:  c = 8'd44;
      7'd4:  c = 8'd46;   7'd5:  c = 8'd48;   7'd6:  c = 8'd49;   7'd7:  c = 8'd51;
      7'd8:  c = 8'd53;   7'd9:  c = 8'd54;   7'd10: c = 8'd56;   7'd11: c = 8'd58;
      7'd12: c = 8'd60;   7'd13: c = 8'd62;   7'd14: c = 8'd64;   7'd15: c = 8'd66;
      7'd16: c = 8'd68;   7'd17: c = 8'd70;   7'd18: c = 8'd72;   7'd19: c = 8'd74;
      7'd20: c = 8'd76;   7'd21: c = 8'd78;   7'd22: c = 8'd80;   7'd23: c = 8'd82;
      7'd24: c = 8'd84;   7'd25: c = 8'd86;   7'd26: c = 8'd88;   7'd27: c = 8'd90;
      7'd28: c = 8'd93;   7'd29: c = 8'd95;   7'd30: c = 8'd97;   7'd31: c = 8'd99;
      7'd32: c = 8'd101;  7'd33: c = 8'd104;  7'd34: c = 8'd106;  7'd35: c = 8'd108;
      7'd36: c = 8'd110;  7'd37: c = 8'd112;  7'd38: c = 8'd115;  7'd39: c = 8'd117;
      7'd40: c = 8'd119;  7'd41: c = 8'd121;  7'd42: c = 8'd123;  7'd43: c = 8'd126;
      7'd44: c = 8'd128;  7'd45: c = 8'd130;  7'd46: c = 8'd132;  7'd47: c = 8'd134;
      7'd48: c = 8'd136;  7'd49: c = 8'd138;  7'd50: c = 8'd140;  7'd51: c = 8'd142;
      7'd52: c = 8'd145;  7'd53: c = 8'd147;  7'd54: c = 8'd149;  7'd55: c = 8'd150;
      7'd56: c = 8'd152;  7'd57: c = 8'd154;  7'd58: c = 8'd156;  7'd59: c = 8'd158;
      7'd60: c = 8'd160;  7'd61: c = 8'd162;  7'd62: c = 8'd164;  7'd63: c = 8'd165;
      7'd64: c = 8'd167;  7'd65: c = 8'd169;  7'd66: c = 8'd171;  7'd67: c = 8'd172;
      7'd68: c = 8'd174;  7'd69: c = 8'd176;  7'd70: c = 8'd177;  7'd71: c = 8'd179;
      7'd72: c = 8'd180;
      default: c = 8'd180;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/ntcftl_if.sv -----
// ----------------------------------------------------------------------------
// NTC filter and lookup channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntcftl_in_if import ntcftl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                timed_out;

  modport source (output valid, output sample, output timed_out, input ready);
  modport sink   (input valid, input sample, input timed_out, output ready);
endinterface

interface ntcftl_out_if import ntcftl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature;
  logic              valid_res;
  logic              sample_rejected;
  logic              temp_updated;

  modport source (output valid, output temperature, output valid_res,
                  output sample_rejected, output temp_updated, input ready);
  modport sink   (input valid, input temperature, input valid_res,
                  input sample_rejected, input temp_updated, output ready);
endinterface

interface ntcftl_cfg_if import ntcftl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ntcftl_walk.sv -----
// ----------------------------------------------------------------------------
// NTC calibration table walker
// Steps through the calibration table one entry per cycle with one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcftl_walk
  import ntcftl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ntcftl_walk_req_t req,
  output ntcftl_walk_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic [TEMP_W-1:0] idx_r, idx_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              hit;
  logic              last;

  // First entry whose code exceeds the input ends the walk one degree below it
  assign hit  = code_r < cal_code(idx_r);
  assign last = idx_r == TOP_IDX;

  assign rsp.done = busy_r && (hit || last);
  assign rsp.temp = hit ? (idx_r - TEMP_W'(1)) : idx_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    code_nxt = code_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        idx_nxt  = TEMP_W'(1);
        code_nxt = req.code;
      end
    end else if (rsp.done) begin
      busy_nxt = 1'b0;
    end else begin
      idx_nxt = idx_r + TEMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    idx_r  <= idx_nxt;
    code_r <= code_nxt;
  end

endmodule

`default_nettype wire

// ----- src/ntc_filter_and_temperature_lookup_core.sv -----
// ----------------------------------------------------------------------------
// NTC filter and temperature lookup core
// Rejects bad thermistor samples, smooths good ones and publishes a
// temperature from the calibration table.
// ----------------------------------------------------------------------------
// One sample item in, one result item out. An item whose sample is rejected
// or needs no lookup goes from the filter state straight to output; when a
// lookup runs, the table walker compares the filtered code against one
// calibration entry per cycle, so the lookup for T degrees takes T+1 steps,
// and 72 steps at the top of the table. The input
// is not ready from acceptance until the result sits in the output register;
// the output register lets the next item enter while a result waits.
// Register writes are taken at any time (ready is held high) but should only
// be issued while the block is idle.
`default_nettype none

module ntc_filter_and_temperature_lookup_core
  import ntcftl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ntcftl_in_if.sink    in_ch,
  ntcftl_out_if.source out_ch,
  ntcftl_cfg_if.sink   cfg_ch
);

`include "ntc_filter_and_temperature_lookup_core_assert.svh"

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // wait for a sample item
  localparam logic [1:0] S_FILT = 2'd1;  // check limits, update filter and count
  localparam logic [1:0] S_LOOK = 2'd2;  // table walk in progress
  localparam logic [1:0] S_OUT  = 2'd3;  // hand result to the output register

  logic [1:0]          state_r, state_nxt;

  // Configuration registers
  logic [SAMPLE_W-1:0] open_lim_r, open_lim_nxt;
  logic [SAMPLE_W-1:0] short_lim_r, short_lim_nxt;
  logic [COUNT_W-1:0]  pub_smp_r, pub_smp_nxt;

  // Filter and publish state
  logic [SAMPLE_W-1:0] level_r, level_nxt;
  logic                seeded_r, seeded_nxt;
  logic                published_r, published_nxt;
  logic [TEMP_W-1:0]   cur_temp_r, cur_temp_nxt;
  logic [COUNT_W-1:0]  pub_cnt_r, pub_cnt_nxt;

  // Per-item working registers
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic                tout_r, tout_nxt;
  logic                rej_r, rej_nxt;
  logic                upd_r, upd_nxt;
  logic                first_r, first_nxt;
  logic                start_r, start_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]   out_temp_r, out_temp_nxt;
  logic                out_vres_r, out_vres_nxt;
  logic                out_rej_r, out_rej_nxt;
  logic                out_upd_r, out_upd_nxt;

  logic                reject;
  logic [SAMPLE_W+2:0] avg_sum;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                out_free;

  ntcftl_walk_req_t    walk_req;
  ntcftl_walk_rsp_t    walk_rsp;

  assign in_ch.ready = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.temperature     = out_temp_r;
  assign out_ch.valid_res       = out_vres_r;
  assign out_ch.sample_rejected = out_rej_r;
  assign out_ch.temp_updated    = out_upd_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // Timeout, open sensor or shorted sensor
  assign reject = tout_r || (smp_r < open_lim_r) || (smp_r > short_lim_r);

  // 7*level + sample, then drop three bits: floor of the weighted average
  assign avg_sum = {level_r, 3'b000} - {3'b000, level_r} + {3'b000, smp_r};
  assign cnt_inc = pub_cnt_r + COUNT_W'(1);

  // Walker samples the code the cycle after the filter has been updated
  assign walk_req.start = start_r;
  assign walk_req.code  = level_r[CODE_SHIFT +: CODE_W];

  ntcftl_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (walk_req),
    .rsp   (walk_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    open_lim_nxt  = open_lim_r;
    short_lim_nxt = short_lim_r;
    pub_smp_nxt   = pub_smp_r;
    level_nxt     = level_r;
    seeded_nxt    = seeded_r;
    published_nxt = published_r;
    cur_temp_nxt  = cur_temp_r;
    pub_cnt_nxt   = pub_cnt_r;
    smp_nxt       = smp_r;
    tout_nxt      = tout_r;
    rej_nxt       = rej_r;
    upd_nxt       = upd_r;
    first_nxt     = first_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    out_vres_nxt  = out_vres_r;
    out_rej_nxt   = out_rej_r;
    out_upd_nxt   = out_upd_r;

    // Register writes; indexes past the list are dropped
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OPEN_LIMIT:  open_lim_nxt  = cfg_ch.data;
        CFG_SHORT_LIMIT: short_lim_nxt = cfg_ch.data;
        CFG_PUBLISH:     pub_smp_nxt   = cfg_ch.data[COUNT_W-1:0];
        default: ;
      endcase
    end

    // Retire the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          smp_nxt   = in_ch.sample;
          tout_nxt  = in_ch.timed_out;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        rej_nxt   = reject;
        upd_nxt   = 1'b0;
        first_nxt = 1'b0;
        if (reject) begin
          state_nxt = S_OUT;
        end else begin
          seeded_nxt = 1'b1;
          level_nxt  = seeded_r ? avg_sum[SAMPLE_W+2:3] : smp_r;
          if (!published_r) begin
            // First good sample publishes at once
            published_nxt = 1'b1;
            pub_cnt_nxt   = '0;
            upd_nxt       = 1'b1;
            first_nxt     = 1'b1;
            start_nxt     = 1'b1;
            state_nxt     = S_LOOK;
          end else if (cnt_inc >= pub_smp_r) begin
            pub_cnt_nxt = '0;
            start_nxt   = 1'b1;
            state_nxt   = S_LOOK;
          end else begin
            pub_cnt_nxt = cnt_inc;
            state_nxt   = S_OUT;
          end
        end
      end
      S_LOOK: begin
        if (walk_rsp.done) begin
          if (first_r || (walk_rsp.temp != cur_temp_r)) begin
            cur_temp_nxt = walk_rsp.temp;
            upd_nxt      = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = cur_temp_r;
          out_vres_nxt  = published_r;
          out_rej_nxt   = rej_r;
          out_upd_nxt   = upd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_lim_r  <= OPEN_LIMIT_RST;
      short_lim_r <= SHORT_LIMIT_RST;
      pub_smp_r   <= PUBLISH_RST;
      level_r     <= LEVEL_RST;
      seeded_r    <= 1'b0;
      published_r <= 1'b0;
      cur_temp_r  <= TEMP_RST;
      pub_cnt_r   <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_lim_r  <= open_lim_nxt;
      short_lim_r <= short_lim_nxt;
      pub_smp_r   <= pub_smp_nxt;
      level_r     <= level_nxt;
      seeded_r    <= seeded_nxt;
      published_r <= published_nxt;
      cur_temp_r  <= cur_temp_nxt;
      pub_cnt_r   <= pub_cnt_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r      <= smp_nxt;
    tout_r     <= tout_nxt;
    rej_r      <= rej_nxt;
    upd_r      <= upd_nxt;
    first_r    <= first_nxt;
    out_temp_r <= out_temp_nxt;
    out_vres_r <= out_vres_nxt;
    out_rej_r  <= out_rej_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  // Walker answers only while the sequencer waits for it
  `NTCFTL_ASSERT_NOW(a_walk_done_in_look, walk_rsp.done, state_r == S_LOOK)
  // A lookup request always moves the sequencer into the walk
  `NTCFTL_ASSERT_NOW(a_start_in_look, start_r, state_r == S_LOOK)
  // Published temperature never leaves the table range
  `NTCFTL_ASSERT_NOW(a_temp_range, out_valid_r, out_temp_r <= TOP_IDX)
  // A rejected sample never reports an update
  `NTCFTL_ASSERT_NOW(a_rej_no_upd, out_valid_r && out_rej_r, !out_upd_r)
  // An update implies a published temperature
  `NTCFTL_ASSERT_NOW(a_upd_has_res, out_valid_r && out_upd_r, out_vres_r)
  // An accepted item is next checked against the limits
  `NTCFTL_ASSERT_NEXT(a_accept_to_filt, in_ch.valid && in_ch.ready, state_r == S_FILT)

endmodule

`default_nettype wire
